// ===== src/clarke_park_forward_core_macros.svh =====
// Assertion macros for the forward Clarke-Park core.
// Included by the top level; no other dependencies.
`ifndef CLARKE_PARK_FORWARD_CORE_MACROS_SVH
`define CLARKE_PARK_FORWARD_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define CLPK_ASSERT_SAME(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("clarke_park_forward_core: same-cycle check failed");
`define CLPK_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("clarke_park_forward_core: next-cycle check failed");
`else
`define CLPK_ASSERT_SAME(label, clk, rst_n, cond, expr)
`define CLPK_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif

`endif

// ===== src/clpk_pkg.sv =====
// Shared widths, constants and pipeline control type for the Clarke-Park core.
// No dependencies; imported by every module of the block.
package clpk_pkg;

  localparam int CUR_W   = 16;  // phase current, Q1.15
  localparam int ANG_W   = 16;  // angle field on the port
  localparam int OUT_W   = 17;  // d and q, Q2.15
  localparam int TAB_W   = 15;  // sine table entry, 0..32767
  localparam int TRIG_W  = 16;  // signed sine or cosine
  localparam int AB_W    = 18;  // a + 2b
  localparam int PRODB_W = 36;  // (a + 2b) * 1/sqrt(3)
  localparam int BETA_W  = 18;  // beta, full width
  localparam int PAC_W   = 32;  // current times trig
  localparam int PBS_W   = 34;  // beta times trig
  localparam int SUM_W   = 35;  // sum of two products
  localparam int FULL_W  = 20;  // sum after the Q30 to Q15 shift

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 40;

  localparam logic signed [AB_W-1:0]   INV_SQRT3_Q16 = 18'sd37837;
  localparam logic signed [PRODB_W-1:0] BETA_ROUND   = 36'sd32768;
  localparam logic signed [SUM_W-1:0]  OUT_ROUND     = 35'sd16384;
  localparam logic signed [FULL_W-1:0] OUT_MAX       = 20'sd65535;
  localparam logic signed [FULL_W-1:0] OUT_MIN       = -20'sd65536;
  localparam logic [63:0]              HALF_PI_Q30   = 64'd1686629713;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // Load enables of the register stages after the input stage.
  typedef struct packed {
    logic en2;
    logic en3;
    logic en4;
    logic en5;
  } pipe_en_t;

endpackage

// ===== src/clpk_sincos.sv =====
// Sine and cosine lookup: quarter-wave ROM with two registered read ports,
// then the quadrant fold. Depends on clpk_pkg.
module clpk_sincos #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                                   clk,
  input  clpk_pkg::pipe_en_t                     en,
  input  logic [SINE_TABLE_BITS-1:0]             idx,
  input  logic [1:0]                             quad,
  output logic signed [clpk_pkg::TRIG_W-1:0]     sin_o,
  output logic signed [clpk_pkg::TRIG_W-1:0]     cos_o
);
  import clpk_pkg::*;

  localparam int N = 1 << SINE_TABLE_BITS;
  localparam logic [SINE_TABLE_BITS:0] N_ADDR = (SINE_TABLE_BITS + 1)'(N);

  typedef logic [TAB_W-1:0] rom_t [0:N];

  // Shift-and-subtract long division; it only runs while the table is built.
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int bit_i = 63; bit_i >= 0; bit_i--) begin
      rem = {rem[63:0], num[bit_i]};
      if (rem >= {1'b0, den}) begin
        rem        = rem - {1'b0, den};
        quo[bit_i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // One table entry: sin(k*pi/(2N)) from a Taylor series in Q2.30, scaled by 32767.
  function automatic logic [TAB_W-1:0] sine_entry(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        dv;
    logic [63:0]        e;
    logic signed [63:0] sum;
    int                 n;
    x    = (HALF_PI_Q30 * 64'(k)) >> SINE_TABLE_BITS;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    for (n = 1; n <= 12; n++) begin
      dv   = 64'((2 * n) * (2 * n + 1));
      term = div_u64((term * x2) >> 30, dv);
      if ((n & 1) != 0) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    e = (unsigned'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (e > 64'd32767) begin
      e = 64'd32767;
    end
    return TAB_W'(e);
  endfunction

  function automatic rom_t build_rom();
    rom_t rom;
    for (int k = 0; k <= N; k++) begin
      rom[k] = sine_entry(k);
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [SINE_TABLE_BITS:0] addr_i;
  logic [SINE_TABLE_BITS:0] addr_ni;
  logic [TAB_W-1:0]         ti_r;
  logic [TAB_W-1:0]         tni_r;
  logic [1:0]               quad_r;
  logic signed [TRIG_W-1:0] ti_s;
  logic signed [TRIG_W-1:0] tni_s;
  logic signed [TRIG_W-1:0] sin_nxt;
  logic signed [TRIG_W-1:0] cos_nxt;
  logic signed [TRIG_W-1:0] sin_r;
  logic signed [TRIG_W-1:0] cos_r;

  assign addr_i  = {1'b0, idx};
  assign addr_ni = N_ADDR - addr_i;

  always_ff @(posedge clk) begin
    if (en.en2) begin
      ti_r   <= SINE_ROM[addr_i];
      tni_r  <= SINE_ROM[addr_ni];
      quad_r <= quad;
    end
  end

  assign ti_s  = signed'({1'b0, ti_r});
  assign tni_s = signed'({1'b0, tni_r});

  always_comb begin
    case (quad_r)
      QUAD_0: begin
        sin_nxt = ti_s;
        cos_nxt = tni_s;
      end
      QUAD_1: begin
        sin_nxt = tni_s;
        cos_nxt = -ti_s;
      end
      QUAD_2: begin
        sin_nxt = -ti_s;
        cos_nxt = -tni_s;
      end
      default: begin
        sin_nxt = -tni_s;
        cos_nxt = ti_s;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.en3) begin
      sin_r <= sin_nxt;
      cos_r <= cos_nxt;
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

// ===== src/clpk_rotate.sv =====
// Park rotation: four registered products, then round, shift and saturate.
// Depends on clpk_pkg.
module clpk_rotate (
  input  logic                                  clk,
  input  clpk_pkg::pipe_en_t                    en,
  input  logic signed [clpk_pkg::CUR_W-1:0]     alpha,
  input  logic signed [clpk_pkg::BETA_W-1:0]    beta,
  input  logic signed [clpk_pkg::TRIG_W-1:0]    sin_i,
  input  logic signed [clpk_pkg::TRIG_W-1:0]    cos_i,
  output logic signed [clpk_pkg::OUT_W-1:0]     d_o,
  output logic signed [clpk_pkg::OUT_W-1:0]     q_o
);
  import clpk_pkg::*;

  logic signed [PAC_W-1:0]  p_ac_r;
  logic signed [PAC_W-1:0]  p_as_r;
  logic signed [PBS_W-1:0]  p_bs_r;
  logic signed [PBS_W-1:0]  p_bc_r;
  logic signed [SUM_W-1:0]  sum_d;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [FULL_W-1:0] full_d;
  logic signed [FULL_W-1:0] full_q;
  logic signed [OUT_W-1:0]  d_nxt;
  logic signed [OUT_W-1:0]  q_nxt;
  logic signed [OUT_W-1:0]  d_r;
  logic signed [OUT_W-1:0]  q_r;

  always_ff @(posedge clk) begin
    if (en.en4) begin
      p_ac_r <= PAC_W'(alpha) * PAC_W'(cos_i);
      p_as_r <= PAC_W'(alpha) * PAC_W'(sin_i);
      p_bs_r <= PBS_W'(beta) * PBS_W'(sin_i);
      p_bc_r <= PBS_W'(beta) * PBS_W'(cos_i);
    end
  end

  // Arithmetic shift of the rounded Q30 sum floors it to Q15.
  always_comb begin
    sum_d  = SUM_W'(p_ac_r) + SUM_W'(p_bs_r) + OUT_ROUND;
    sum_q  = SUM_W'(p_bc_r) - SUM_W'(p_as_r) + OUT_ROUND;
    full_d = sum_d[SUM_W-1:SUM_W-FULL_W];
    full_q = sum_q[SUM_W-1:SUM_W-FULL_W];
    if (full_d > OUT_MAX) begin
      d_nxt = OUT_W'(OUT_MAX);
    end else if (full_d < OUT_MIN) begin
      d_nxt = OUT_W'(OUT_MIN);
    end else begin
      d_nxt = OUT_W'(full_d);
    end
    if (full_q > OUT_MAX) begin
      q_nxt = OUT_W'(OUT_MAX);
    end else if (full_q < OUT_MIN) begin
      q_nxt = OUT_W'(OUT_MIN);
    end else begin
      q_nxt = OUT_W'(full_q);
    end
  end

  always_ff @(posedge clk) begin
    if (en.en5) begin
      d_r <= d_nxt;
      q_r <= q_nxt;
    end
  end

  assign d_o = d_r;
  assign q_o = q_r;

endmodule

// ===== src/clarke_park_forward_core.sv =====
// Top level of the forward Clarke-Park core: handshake, input stage and beta path.
// Depends on clpk_pkg, clpk_sincos, clpk_rotate and the assertion macro header.
//
// Usage:
//   The input channel (in_tvalid, in_tready, in_tdata) carries one item per
//   sample: phase currents a and b and the rotor angle. The result channel
//   (out_tvalid, out_tready, out_tdata) returns one item with the d and q
//   currents for every input item, in order.
//   An accepted item fills the first of five register stages (input, sine
//   ROM read and beta multiply, quadrant fold and beta round, four products,
//   and sum with saturation) and moves through them in order; out_tvalid
//   rises when it reaches the last one.
//   Throughput is one item per cycle unless the receiver stalls; the two
//   ROM read ports give the sine and cosine of one item in the same cycle.
//   Each stage has its own valid bit and loads when it is empty or when the
//   stage after it moves, so empty stages keep filling while out_tready is
//   low. With all five stages full and the receiver stalled, in_tready drops
//   and every item holds its place until out_tready returns.
//   Reset (rst_n low, synchronous) empties the pipeline; no result is pending
//   afterwards. The sine table is constant and needs no setup time.
`include "clarke_park_forward_core_macros.svh"

module clarke_park_forward_core #(
  parameter int ANGLE_BITS      = 16,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [15:0] current_a, [31:16] current_b, [47:32] rotor_angle
  input  logic [clpk_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [16:0] direct_current, [33:17] quadrature_current, [39:34] zero
  output logic [clpk_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import clpk_pkg::*;

  localparam int FB = ANGLE_BITS - 2;

  logic signed [CUR_W-1:0]   in_a;
  logic signed [CUR_W-1:0]   in_b;
  logic [ANGLE_BITS-1:0]     ang;
  logic [FB-1:0]             frac;
  logic [SINE_TABLE_BITS-1:0] idx_nxt;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1;
  pipe_en_t en;

  logic signed [AB_W-1:0]    ab1_r;
  logic signed [CUR_W-1:0]   a1_r;
  logic [1:0]                quad1_r;
  logic [SINE_TABLE_BITS-1:0] idx1_r;
  logic signed [PRODB_W-1:0] prodb2_r;
  logic signed [CUR_W-1:0]   a2_r;
  logic signed [PRODB_W-1:0] beta_sum;
  logic signed [BETA_W-1:0]  beta3_r;
  logic signed [CUR_W-1:0]   a3_r;
  logic signed [TRIG_W-1:0]  sin3;
  logic signed [TRIG_W-1:0]  cos3;
  logic signed [OUT_W-1:0]   d5;
  logic signed [OUT_W-1:0]   q5;

  assign in_a = signed'(in_tdata[CUR_W-1:0]);
  assign in_b = signed'(in_tdata[2*CUR_W-1:CUR_W]);
  assign ang  = ANGLE_BITS'(in_tdata[2*CUR_W+ANG_W-1:2*CUR_W]);
  assign frac = ang[FB-1:0];

  // The index keeps the top bits of the angle fraction, zero padded when short.
  generate
    if (FB >= SINE_TABLE_BITS) begin : g_idx_cut
      assign idx_nxt = frac[FB-1 -: SINE_TABLE_BITS];
    end else begin : g_idx_pad
      assign idx_nxt = {frac, {(SINE_TABLE_BITS - FB){1'b0}}};
    end
  endgenerate

  // A stage loads when it is empty or when its content moves on.
  assign en.en5    = !v5_r || out_tready;
  assign en.en4    = !v4_r || en.en5;
  assign en.en3    = !v3_r || en.en4;
  assign en.en2    = !v2_r || en.en3;
  assign en1       = !v1_r || en.en2;
  assign in_tready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_tvalid;
      end
      if (en.en2) begin
        v2_r <= v1_r;
      end
      if (en.en3) begin
        v3_r <= v2_r;
      end
      if (en.en4) begin
        v4_r <= v3_r;
      end
      if (en.en5) begin
        v5_r <= v4_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      ab1_r   <= AB_W'(in_a) + AB_W'(in_b) + AB_W'(in_b);
      a1_r    <= in_a;
      quad1_r <= ang[ANGLE_BITS-1:ANGLE_BITS-2];
      idx1_r  <= idx_nxt;
    end
    if (en.en2) begin
      prodb2_r <= PRODB_W'(ab1_r) * PRODB_W'(INV_SQRT3_Q16);
      a2_r     <= a1_r;
    end
    if (en.en3) begin
      beta3_r <= beta_sum[BETA_W+15:16];
      a3_r    <= a2_r;
    end
  end

  // Rounded product shifted right by 16; the slice is the floored beta.
  assign beta_sum = prodb2_r + BETA_ROUND;

  clpk_sincos #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_sincos (
    .clk   (clk),
    .en    (en),
    .idx   (idx1_r),
    .quad  (quad1_r),
    .sin_o (sin3),
    .cos_o (cos3)
  );

  clpk_rotate u_rotate (
    .clk   (clk),
    .en    (en),
    .alpha (a3_r),
    .beta  (beta3_r),
    .sin_i (sin3),
    .cos_i (cos3),
    .d_o   (d5),
    .q_o   (q5)
  );

  assign out_tvalid = v5_r;
  assign out_tdata  = {{(OUT_DATA_W - 2*OUT_W){1'b0}}, q5, d5};

  `CLPK_ASSERT_SAME(a_empty_head_ready, clk, rst_n, !v1_r, in_tready)
  `CLPK_ASSERT_NEXT(a_accept_fills_head, clk, rst_n, in_tvalid && in_tready, v1_r)
  `CLPK_ASSERT_NEXT(a_head_holds_on_stall, clk, rst_n, v1_r && !en.en2, v1_r)
  `CLPK_ASSERT_NEXT(a_stage4_reaches_out, clk, rst_n, v4_r && out_tready, out_tvalid)

endmodule
